/* design/sorted_table_quantile_lookup_unit_macros.svh */
// ----------------------------------------------------------------------------
// sorted table quantile lookup - assertion macros
// shared concurrent checks, written one use to a line in the asserting file
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_QUANTILE_LOOKUP_UNIT_MACROS_SVH
`define SORTED_TABLE_QUANTILE_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication
`define STQL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STQL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/stql_pkg.sv */
// ----------------------------------------------------------------------------
// stql_pkg
// shared constants and codes of the sorted table quantile lookup unit
// ----------------------------------------------------------------------------
package stql_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // quantile is unsigned q0.16 with room for 1.0
  localparam int QUANT_W = 17;
  // rank is in halves, so the scale is 65536 / 2
  localparam int HALF_SH = 15;
  localparam int STEP_W  = $clog2(QUANT_W);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_QUERY_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

endpackage

/* design/sorted_table_quantile_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sorted_table_quantile_lookup_unit
// empirical cdf lookup over a table of signed values loaded in ascending order
// ----------------------------------------------------------------------------
// usage:
//   a command word (action, value) is taken at a clock edge with start high
//   and busy low. every command returns exactly one result word, shown on
//   rank_halves, quantile_q16, entry_count and status for one cycle while
//   done is high; the receiver has no way to stall it.
//   load appends value at the end of the table, clear drops the entry count,
//   query finds the key's rank (in halves) and its quantile in q0.16.
// timing:
//   load, clear, reserved action and query on an empty table: the result
//   shows in the cycle after the command is taken.
//   query: S_FIRST and S_LAST test the first and the last entry, then
//   S_SEARCH makes the bisection probes (at most about log2(n) + 1, so 11
//   for 1024 entries), then S_DIV waits on the bit-serial divider, and
//   the result word is registered out; the pace is set by the table ram
//   read port (one probe per cycle) and the one-bit-per-cycle divider.
//   one command at a time; busy stays high until the result is shown, and a
//   new command can be taken in the same cycle as that result.
// reset:
//   rst clears the entry count and the controller; table contents are not
//   cleared and only entries below the entry count are used.
// ----------------------------------------------------------------------------
`include "sorted_table_quantile_lookup_unit_macros.svh"

module sorted_table_quantile_lookup_unit #(
  parameter int TABLE_DEPTH = stql_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stql_pkg::DEF_VALUE_WIDTH,
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int RANK_W  = COUNT_W + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [stql_pkg::ACTION_W-1:0] action,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          done,
  output logic [RANK_W-1:0]             rank_halves,
  output logic [stql_pkg::QUANT_W-1:0]  quantile_q16,
  output logic [COUNT_W-1:0]            entry_count,
  output logic [stql_pkg::STATUS_W-1:0] status
);
  import stql_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_DIV
  } state_t;

  state_t state;

  // entry count, key under search and bisection bounds (hi kept as hi + 1)
  logic [COUNT_W-1:0]            count;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [COUNT_W-1:0]            lo;
  logic [COUNT_W:0]              hip1;
  logic [ADDR_W-1:0]             mid;
  logic [RANK_W-1:0]             rank;

  // table ram
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // divider handoff
  logic                div_start;
  logic                div_done;
  logic [QUANT_W-1:0]  div_q;

  // bisection step, worked out on the entry read at mid
  logic                key_lt;
  logic                key_gt;
  logic [COUNT_W-1:0]  lo_next;
  logic [COUNT_W:0]    hip1_next;
  logic [COUNT_W+1:0]  mid_sum;
  logic [ADDR_W-1:0]   mid_next;
  logic                probe_hit;
  logic                probe_more;
  logic                accept;

  // terms of the checks at the end
  logic                full_load_cmd;
  logic                full_drop_word;
  logic                query_word;
  logic                query_in_range;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // loads only land while idle and queries only use entries below the count,
  // so a query never uses an entry while it is being written
  assign ram_we = accept && (action == ACT_LOAD) && (count < FULL_COUNT);

  stql_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(count)),
    .wdata (value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stql_div #(
    .COUNT_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rank     (rank),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  assign key_lt = key < $signed(ram_rdata);
  assign key_gt = key > $signed(ram_rdata);

  always_comb begin
    lo_next   = lo;
    hip1_next = hip1;
    probe_hit = 1'b0;
    if (key_lt) begin
      hip1_next = (COUNT_W+1)'(mid);
    end else if (key_gt) begin
      lo_next = COUNT_W'(mid) + COUNT_W'(1);
    end else begin
      probe_hit = 1'b1;
    end
    probe_more = (COUNT_W+1)'(lo_next) < hip1_next;
    // mid = (lo + hi) / 2 with hi = hip1 - 1; only used while lo <= hi
    mid_sum    = (COUNT_W+2)'(lo_next) + (COUNT_W+2)'(hip1_next) - (COUNT_W+2)'(1);
    mid_next   = ADDR_W'(mid_sum >> 1);
  end

  // read address is driven in the state before the one that uses the data
  always_comb begin
    unique case (state)
      S_IDLE:   ram_raddr = '0;
      S_FIRST:  ram_raddr = ADDR_W'(count - COUNT_W'(1));
      S_LAST:   ram_raddr = ADDR_W'(count >> 1);
      S_SEARCH: ram_raddr = mid_next;
      default:  ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key          <= value;
            rank_halves  <= '0;
            quantile_q16 <= '0;
            unique case (action)
              ACT_QUERY: begin
                if (count == '0) begin
                  entry_count <= count;
                  status      <= ST_EMPTY;
                  done        <= 1'b1;
                end else begin
                  state <= S_FIRST;
                end
              end
              ACT_LOAD: begin
                done <= 1'b1;
                if (count < FULL_COUNT) begin
                  count       <= count + COUNT_W'(1);
                  entry_count <= count + COUNT_W'(1);
                  status      <= ST_DONE;
                end else begin
                  entry_count <= count;
                  status      <= ST_FULL;
                end
              end
              ACT_CLEAR: begin
                count       <= '0;
                entry_count <= '0;
                status      <= ST_DONE;
                done        <= 1'b1;
              end
              default: begin
                entry_count <= count;
                status      <= ST_DONE;
                done        <= 1'b1;
              end
            endcase
          end
        end
        S_FIRST: begin
          // below the first entry
          if (key_lt) begin
            rank      <= '0;
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          // at or above the last entry
          if (!key_lt) begin
            rank      <= {count, 1'b0};
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            lo    <= '0;
            hip1  <= (COUNT_W+1)'(count) + (COUNT_W+1)'(1);
            mid   <= ADDR_W'(count >> 1);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (probe_hit) begin
            rank      <= {COUNT_W'(mid) + COUNT_W'(1), 1'b0};
            div_start <= 1'b1;
            state     <= S_DIV;
          end else if (!probe_more) begin
            rank      <= {lo_next, 1'b1};
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            lo   <= lo_next;
            hip1 <= hip1_next;
            mid  <= mid_next;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rank_halves  <= rank;
            quantile_q16 <= div_q;
            entry_count  <= count;
            status       <= ST_QUERY_OK;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign full_load_cmd  = accept && (action == ACT_LOAD) && (count == FULL_COUNT);
  assign full_drop_word = done && (status == ST_FULL) && (entry_count == FULL_COUNT);
  assign query_word     = done && (status == ST_QUERY_OK);
  assign query_in_range = (rank_halves <= {entry_count, 1'b0}) &&
                          (quantile_q16 <= QUANT_W'(65536)) && (entry_count != '0);

  // every taken command either shows its result next or keeps the unit busy
  `STQL_ASSERT_NEXT(a_cmd_progress, clk, rst, accept, busy || done, "command lost")
  // a result is only shown once the controller is back at idle
  `STQL_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result while busy")
  // a load into a full table is dropped and the count stays at depth
  `STQL_ASSERT_NEXT(a_full_drop, clk, rst, full_load_cmd, full_drop_word, "full load kept")
  // a query result never ranks past the entry count nor passes 1.0
  `STQL_ASSERT_NOW(a_rank_range, clk, rst, query_word, query_in_range, "query out of range")

endmodule

/* design/stql_ram.sv */
// ----------------------------------------------------------------------------
// stql_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module stql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/stql_div.sv */
// ----------------------------------------------------------------------------
// stql_div
// restoring divider, one quotient bit a cycle: floor(rank * 32768 / count)
// ----------------------------------------------------------------------------
module stql_div #(
  parameter int COUNT_W = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [COUNT_W:0]             rank,
  input  logic [COUNT_W-1:0]           divisor,
  output logic                         done,
  output logic [stql_pkg::QUANT_W-1:0] quotient
);
  import stql_pkg::*;

  localparam int DIVD_W = COUNT_W + 1 + HALF_SH;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUANT_W - 1);

  logic                running;
  logic [STEP_W-1:0]   step;
  logic [COUNT_W:0]    rem;
  logic [QUANT_W-1:0]  sh;
  logic [DIVD_W-1:0]   dividend;
  logic [COUNT_W+1:0]  trial;
  logic                ge;

  // quotient fits in QUANT_W bits, so the high dividend bits seed the remainder
  assign dividend = {rank, {HALF_SH{1'b0}}};
  assign trial    = {rem, sh[QUANT_W-1]};
  assign ge       = trial >= (COUNT_W+2)'(divisor);
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        rem     <= (COUNT_W+1)'(dividend >> QUANT_W);
        sh      <= dividend[QUANT_W-1:0];
      end else if (running) begin
        rem  <= ge ? (COUNT_W+1)'(trial - (COUNT_W+2)'(divisor)) : (COUNT_W+1)'(trial);
        sh   <= {sh[QUANT_W-2:0], ge};
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

/* tb/sv/sorted_table_quantile_lookup_unit_tb.sv */
// ----------------------------------------------------------------------------
// sorted_table_quantile_lookup_unit_tb
// self-checking bench for the sorted table quantile lookup unit: command words
// go in through start/busy in random bursts, every done word is checked field
// by field against a shadow table that predicts rank, quantile, count and status
// ----------------------------------------------------------------------------
module sorted_table_quantile_lookup_unit_tb;
  import stql_pkg::*;

  localparam int TB_DEPTH   = DEF_TABLE_DEPTH;
  localparam int TB_VALUE_W = DEF_VALUE_WIDTH;
  localparam int TB_COUNT_W = $clog2(TB_DEPTH + 1);
  localparam int TB_RANK_W  = TB_COUNT_W + 1;

  // action 3 has no meaning but still answers with a done word
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

  // a command word as it goes to the block
  typedef struct {
    logic [ACTION_W-1:0] action;
    int                  value;
  } cmd_t;

  // a result word as the block should show it
  typedef struct {
    logic [TB_RANK_W-1:0]  rank;
    logic [QUANT_W-1:0]    quant;
    logic [TB_COUNT_W-1:0] entries;
    logic [STATUS_W-1:0]   st;
  } result_t;

  // clock, reset and block inputs, known from time zero, then the block outputs
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [ACTION_W-1:0]           action = ACT_QUERY;
  logic signed [TB_VALUE_W-1:0]  value = '0;
  logic                          busy;
  logic                          done;
  logic [TB_RANK_W-1:0]          rank_halves;
  logic [QUANT_W-1:0]            quantile_q16;
  logic [TB_COUNT_W-1:0]         entry_count;
  logic [STATUS_W-1:0]           status;

  // words waiting to be sent, and results predicted but not yet seen
  cmd_t    pending_cmds[$];
  result_t predicted_results[$];

  // shadow copy of the table and its fill level
  int          shadow_table [TB_DEPTH];
  int unsigned shadow_fill = 0;

  int mismatch_count = 0;
  int result_index   = 0;

  // sender pacing: words in the current burst, idle cycles still to wait
  int burst_left = 1;
  int gap_left   = 0;

  sorted_table_quantile_lookup_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .value        (value),
    .done         (done),
    .rank_halves  (rank_halves),
    .quantile_q16 (quantile_q16),
    .entry_count  (entry_count),
    .status       (status)
  );

  always #4 clk = ~clk;

  // reset held high from time zero and released once
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction: applies one command word to the shadow table and returns the
  // result word it must cause
  // ---------------------------------------------------------------------------
  function automatic result_t predict_word(input cmd_t c);
    result_t     r;
    int          lo;
    int          hi;
    int          mid;
    int          key;
    int unsigned n;
    int unsigned rank;
    bit          hit;
    r.rank  = '0;
    r.quant = '0;
    r.st    = ST_DONE;
    n       = shadow_fill;
    key     = c.value;
    rank    = 0;
    case (c.action)
      ACT_QUERY: begin
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else begin
          // the two end tests come first, bisection only between them
          if (key < shadow_table[0]) begin
            rank = 0;
          end else if (key >= shadow_table[n-1]) begin
            rank = 2 * n;
          end else begin
            lo  = 0;
            hi  = int'(n);
            mid = 0;
            hit = 1'b0;
            while (lo <= hi && !hit) begin
              mid = (lo + hi) / 2;
              if (key < shadow_table[mid]) hi = mid - 1;
              else if (key > shadow_table[mid]) lo = mid + 1;
              else hit = 1'b1;
            end
            // exact hit lands on an even rank, a miss between entries on odd
            rank = $unsigned(hit ? 2 * (mid + 1) : 2 * lo + 1);
          end
          r.rank  = TB_RANK_W'(rank);
          // rank is in halves, so scale by 2^15 rather than 2^16
          r.quant = QUANT_W'((rank << HALF_SH) / n);
          r.st    = ST_QUERY_OK;
        end
      end
      ACT_LOAD: begin
        if (shadow_fill < TB_DEPTH) begin
          shadow_table[shadow_fill] = c.value;
          shadow_fill++;
        end else begin
          r.st = ST_FULL;
        end
      end
      ACT_CLEAR: begin
        // old entries stay in the table, only the count drops
        shadow_fill = 0;
      end
      default: ;
    endcase
    r.entries = TB_COUNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on result word %0d: %s got %0d want %0d",
             result_index, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_cmd(input logic [ACTION_W-1:0] a, input int v);
    cmd_t c;
    c.action = a;
    c.value  = v;
    pending_cmds.push_back(c);
  endtask

  // query keys around a loaded set: exact entries, their neighbors, random
  // keys and the two extremes of the value range
  function automatic int pick_key(ref int vals[$]);
    int idx;
    idx = $urandom_range(0, vals.size() - 1);
    case ($urandom_range(0, 6))
      0, 1:    return vals[idx];
      2:       return vals[idx] + 1;
      3:       return vals[idx] - 1;
      4:       return int'($urandom);
      5:       return ($urandom_range(0, 1) != 0) ? int'(32'h8000_0000)
                                                  : int'(32'h7fff_ffff);
      default: return ($urandom_range(0, 1) != 0) ? vals[0] - 1
                                                  : vals[vals.size()-1];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: takes words from pending_cmds in bursts with random gaps; a word is
  // taken at an edge where start is high and busy is low, and its prediction
  // is queued at that edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bit take;
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        predicted_results.push_back(predict_word(pending_cmds.pop_front()));
      end
      // a word not yet taken keeps start high
      go = start && !take;
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          go = 1'b1;
          action <= pending_cmds[0].action;
          value  <= pending_cmds[0].value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // mostly short gaps, now and then a long one or a long run without
            case ($urandom_range(0, 5))
              0:       begin burst_left = $urandom_range(20, 60); gap_left = 0; end
              1:       begin burst_left = $urandom_range(1, 4);
                             gap_left = $urandom_range(15, 40); end
              default: begin burst_left = $urandom_range(1, 12);
                             gap_left = $urandom_range(0, 8); end
            endcase
          end
        end
      end
      start <= go;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done cycle is one result word, checked against the oldest
  // prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        flag_mismatch("unexpected word, status", int'(status), 0);
      end else begin
        want = predicted_results.pop_front();
        if (rank_halves !== want.rank)
          flag_mismatch("rank_halves", int'(rank_halves), int'(want.rank));
        if (quantile_q16 !== want.quant)
          flag_mismatch("quantile_q16", int'(quantile_q16), int'(want.quant));
        if (entry_count !== want.entries)
          flag_mismatch("entry_count", int'(entry_count), int'(want.entries));
        if (status !== want.st)
          flag_mismatch("status", int'(status), int'(want.st));
      end
      result_index++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int vals[$];
    int n_load;
    int n_query;
    int lo_v;
    int k;
    int guard;
    bit narrow;

    // directed: empty table, reserved action, extremes, hits and misses
    add_cmd(ACT_QUERY, 0);
    add_cmd(ACT_RESERVED, int'(32'hffff_ffff));
    add_cmd(ACT_CLEAR, int'(32'h8000_0000));
    add_cmd(ACT_LOAD, -1000);
    add_cmd(ACT_LOAD, -5);
    add_cmd(ACT_LOAD, 0);
    add_cmd(ACT_LOAD, 7);
    add_cmd(ACT_LOAD, 7);
    add_cmd(ACT_LOAD, int'(32'h7fff_ffff));
    add_cmd(ACT_QUERY, int'(32'h8000_0000));  // below the first entry
    add_cmd(ACT_QUERY, -1000);                // equal to the first entry
    add_cmd(ACT_QUERY, -6);                   // between entries
    add_cmd(ACT_QUERY, 0);
    add_cmd(ACT_QUERY, 7);                    // duplicate entries
    add_cmd(ACT_QUERY, 100);
    add_cmd(ACT_QUERY, -1);
    add_cmd(ACT_QUERY, int'(32'h7fff_ffff));  // at the last entry
    add_cmd(ACT_RESERVED, 0);
    add_cmd(ACT_CLEAR, 0);
    add_cmd(ACT_QUERY, 5);                    // empty after clear
    add_cmd(ACT_LOAD, 5);
    add_cmd(ACT_QUERY, 5);                    // single entry table
    add_cmd(ACT_QUERY, 4);

    // random phases, mostly sorted sets followed by queries
    while (pending_cmds.size() < 550) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) add_cmd(ACT_CLEAR, int'($urandom));
        n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                             : $urandom_range(1, 40);
        // narrow sets give many duplicates and exact hits
        narrow = ($urandom_range(0, 2) == 0);
        lo_v   = int'($urandom);
        vals   = {};
        for (k = 0; k < n_load; k++) begin
          if (narrow) vals.push_back(lo_v + int'($urandom_range(0, 2 * n_load)));
          else vals.push_back(int'($urandom));
        end
        vals.sort();
        foreach (vals[i]) add_cmd(ACT_LOAD, vals[i]);
        n_query = $urandom_range(2, 15);
        for (k = 0; k < n_query; k++) begin
          if ($urandom_range(0, 19) == 0) add_cmd(ACT_RESERVED, int'($urandom));
          add_cmd(ACT_QUERY, pick_key(vals));
        end
      end else begin
        // noise: any action on any value, tables out of order
        n_load = $urandom_range(5, 20);
        for (k = 0; k < n_load; k++) begin
          add_cmd(ACTION_W'($urandom_range(0, 3)), int'($urandom));
        end
      end
    end

    // let every word go out, then every result come back
    while (rst || pending_cmds.size() != 0 || start) @(posedge clk);
    guard = 0;
    while (predicted_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    // then wait on so that a stray done word is caught
    repeat (64) @(posedge clk);
    if (predicted_results.size() != 0)
      flag_mismatch("results never seen, count", 0, predicted_results.size());

    if (mismatch_count == 0) begin
      $display("sorted_table_quantile_lookup_unit verification clean");
    end else begin
      $display("sorted_table_quantile_lookup_unit verification failed");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin : watchdog
    #(8 * 1_000_000);
    $display("sorted_table_quantile_lookup_unit verification failed");
    $finish;
  end

endmodule
